FILE: sv/bed_pkg.sv
`timescale 1ns / 1ps

package bed_pkg;

    localparam int ByteW = 8;
    localparam int NibW  = 4;

    typedef logic [ByteW-1:0] byte_t;
    typedef logic [NibW-1:0]  nib_t;

    // Parse phase, one-hot
    typedef enum logic [3:0] {
        PH_PLAIN  = 4'b0001,
        PH_ESC    = 4'b0010,
        PH_HEX_HI = 4'b0100,
        PH_HEX_LO = 4'b1000
    } phase_t;

    // Raw characters
    localparam byte_t CH_BSLASH = 8'h5C;
    localparam byte_t CH_QUOTE  = 8'h22;
    localparam byte_t CH_S      = 8'h73;
    localparam byte_t CH_N      = 8'h6E;
    localparam byte_t CH_T      = 8'h74;
    localparam byte_t CH_R      = 8'h72;
    localparam byte_t CH_F      = 8'h66;
    localparam byte_t CH_V      = 8'h76;
    localparam byte_t CH_X      = 8'h78;
    localparam byte_t CH_0      = 8'h30;
    localparam byte_t CH_9      = 8'h39;
    localparam byte_t CH_LA     = 8'h61;
    localparam byte_t CH_LF     = 8'h66;
    localparam byte_t CH_UA     = 8'h41;
    localparam byte_t CH_UF     = 8'h46;

    // Decoded control characters
    localparam byte_t CODE_SPACE = 8'h20;
    localparam byte_t CODE_LF    = 8'h0A;
    localparam byte_t CODE_TAB   = 8'h09;
    localparam byte_t CODE_CR    = 8'h0D;
    localparam byte_t CODE_FF    = 8'h0C;
    localparam byte_t CODE_VT    = 8'h0B;

    localparam nib_t HEX_TEN = 4'd10;

    // Value of a hex digit; anything else counts as zero
    function automatic nib_t hex_value(input byte_t c);
        byte_t d;
        begin
            d = '0;
            if (c inside {[CH_0:CH_9]}) begin
                d = c - CH_0;
            end
            else if (c inside {[CH_LA:CH_LF]}) begin
                d = c - CH_LA + byte_t'(HEX_TEN);
            end
            else if (c inside {[CH_UA:CH_UF]}) begin
                d = c - CH_UA + byte_t'(HEX_TEN);
            end
            return d[NibW-1:0];
        end
    endfunction

endpackage

FILE: sv/backslash_escape_decoder_top.sv
`timescale 1ns / 1ps

// Backslash escape decoder.
// Input channel s_*: one raw character per transfer in s_tdata, s_tlast marks
// the final character of a string. Output channel m_*: one result per input
// transfer; m_tuser is set when m_tdata carries a decoded character (m_tdata
// is zero otherwise), m_tlast copies the input s_tlast.
// Handles \s \n \t \r \f \v \\ \" and \x with two hex digits; unknown escapes
// drop both characters, a trailing backslash gives nothing.
// Throughput: one character per cycle while m_tready stays high. A character
// taken is held in the input register, decoded against the parse state and
// shown on m_* from the output register.
// The only loop is the 4-bit one-hot parse phase plus the hex high nibble,
// updated in the same cycle the character moves to the output register.
// Reset (rst_n low) empties both registers, returns the parse state to plain
// text and clears the nibble. When m_tready is low the result holds; one more
// character may sit in the input register, after which s_tready drops.
module backslash_escape_decoder_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte[7:0]
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tuser,   // has_byte
    output logic       m_tlast    // end_of_string
);

    logic             in_valid_reg;
    bed_pkg::byte_t   in_byte_reg;
    logic             in_last_reg;

    logic             out_valid_reg;
    bed_pkg::byte_t   out_byte_reg, out_byte_next;
    logic             out_has_reg, out_has_next;
    logic             out_last_reg;

    bed_pkg::phase_t  phase_reg, phase_next;
    bed_pkg::nib_t    nib_reg, nib_next;

    logic             advance;
    logic             in_take;
    bed_pkg::nib_t    digit;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;
    assign digit    = bed_pkg::hex_value(in_byte_reg);

    always_comb
    begin
        out_has_next  = 1'b0;
        out_byte_next = '0;
        phase_next    = phase_reg;
        nib_next      = nib_reg;
        case (phase_reg)
            bed_pkg::PH_PLAIN:
            begin
                if (in_byte_reg == bed_pkg::CH_BSLASH) begin
                    phase_next = bed_pkg::PH_ESC;
                end
                else begin
                    out_has_next  = 1'b1;
                    out_byte_next = in_byte_reg;
                end
            end
            bed_pkg::PH_ESC:
            begin
                phase_next   = bed_pkg::PH_PLAIN;
                out_has_next = 1'b1;
                case (in_byte_reg)
                    bed_pkg::CH_S:      out_byte_next = bed_pkg::CODE_SPACE;
                    bed_pkg::CH_N:      out_byte_next = bed_pkg::CODE_LF;
                    bed_pkg::CH_T:      out_byte_next = bed_pkg::CODE_TAB;
                    bed_pkg::CH_R:      out_byte_next = bed_pkg::CODE_CR;
                    bed_pkg::CH_F:      out_byte_next = bed_pkg::CODE_FF;
                    bed_pkg::CH_V:      out_byte_next = bed_pkg::CODE_VT;
                    bed_pkg::CH_BSLASH: out_byte_next = bed_pkg::CH_BSLASH;
                    bed_pkg::CH_QUOTE:  out_byte_next = bed_pkg::CH_QUOTE;
                    bed_pkg::CH_X:
                    begin
                        // string ending right after \x gives a zero byte
                        nib_next     = '0;
                        phase_next   = bed_pkg::PH_HEX_HI;
                        out_has_next = in_last_reg;
                    end
                    default:            out_has_next = 1'b0;
                endcase
            end
            bed_pkg::PH_HEX_HI:
            begin
                nib_next      = digit;
                phase_next    = bed_pkg::PH_HEX_LO;
                out_has_next  = in_last_reg;
                out_byte_next = in_last_reg ? {digit, 4'h0} : '0;
            end
            bed_pkg::PH_HEX_LO:
            begin
                out_has_next  = 1'b1;
                out_byte_next = {nib_reg, digit};
                phase_next    = bed_pkg::PH_PLAIN;
            end
            default:
            begin
                phase_next = bed_pkg::PH_PLAIN;
            end
        endcase
        if (in_last_reg) begin
            phase_next = bed_pkg::PH_PLAIN;
            nib_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= bed_pkg::PH_PLAIN;
            nib_reg       <= '0;
        end
        else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                phase_reg     <= phase_next;
                nib_reg       <= nib_next;
            end
            else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers: load on transfer, hold otherwise
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance) begin
            out_byte_reg <= out_byte_next;
            out_has_reg  <= out_has_next;
            out_last_reg <= in_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_has_reg;
    assign m_tlast  = out_last_reg;

endmodule

FILE: sv/bed_checker.sv
`timescale 1ns / 1ps

module bed_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);

    // hold a stalled input transfer
    a_s_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("s payload changed while stalled");

    // hold a stalled result
    a_m_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_m_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
        else $error("m payload changed while stalled");

    // an empty output stage never backpressures the input
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output stage");

    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
        else $error("m_tvalid high during reset");

endmodule

bind backslash_escape_decoder_top bed_checker u_bed_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

FILE: bench/backslash_escape_decoder_top_tb.sv
`timescale 1ns / 1ps

typedef struct packed {
    logic           has_byte;
    bed_pkg::byte_t out_byte;
    logic           end_of_string;
} decoded_t;

class escape_scoreboard;
    bed_pkg::phase_t phase;
    bed_pkg::nib_t   hi_nib;
    decoded_t        decoded_q[$];
    int              errors;
    int              results_seen;

    function new();
        phase        = bed_pkg::PH_PLAIN;
        hi_nib       = '0;
        errors       = 0;
        results_seen = 0;
    endfunction

    function bed_pkg::nib_t digit_value(bed_pkg::byte_t c);
        if (c >= bed_pkg::CH_0 && c <= bed_pkg::CH_9)
            return bed_pkg::nib_t'(c - bed_pkg::CH_0);
        if (c >= bed_pkg::CH_LA && c <= bed_pkg::CH_LF)
            return bed_pkg::nib_t'(c - bed_pkg::CH_LA + 8'd10);
        if (c >= bed_pkg::CH_UA && c <= bed_pkg::CH_UF)
            return bed_pkg::nib_t'(c - bed_pkg::CH_UA + 8'd10);
        return '0;
    endfunction

    // Advance the parse state by one character and queue the decoded result
    function void note_char(bed_pkg::byte_t c, logic last);
        decoded_t d;
        d = '0;
        case (phase)
            bed_pkg::PH_PLAIN: begin
                if (c == bed_pkg::CH_BSLASH) begin
                    phase = bed_pkg::PH_ESC;
                end
                else begin
                    d.has_byte = 1'b1;
                    d.out_byte = c;
                end
            end
            bed_pkg::PH_ESC: begin
                phase = bed_pkg::PH_PLAIN;
                d.has_byte = 1'b1;
                case (c)
                    bed_pkg::CH_S:      d.out_byte = bed_pkg::CODE_SPACE;
                    bed_pkg::CH_N:      d.out_byte = bed_pkg::CODE_LF;
                    bed_pkg::CH_T:      d.out_byte = bed_pkg::CODE_TAB;
                    bed_pkg::CH_R:      d.out_byte = bed_pkg::CODE_CR;
                    bed_pkg::CH_F:      d.out_byte = bed_pkg::CODE_FF;
                    bed_pkg::CH_V:      d.out_byte = bed_pkg::CODE_VT;
                    bed_pkg::CH_BSLASH: d.out_byte = bed_pkg::CH_BSLASH;
                    bed_pkg::CH_QUOTE:  d.out_byte = bed_pkg::CH_QUOTE;
                    bed_pkg::CH_X: begin
                        hi_nib     = '0;
                        phase      = bed_pkg::PH_HEX_HI;
                        // string cut right after \x gives a zero byte
                        d.has_byte = last;
                    end
                    default:   d.has_byte = 1'b0;
                endcase
            end
            bed_pkg::PH_HEX_HI: begin
                hi_nib = digit_value(c);
                phase  = bed_pkg::PH_HEX_LO;
                if (last) begin
                    d.has_byte = 1'b1;
                    d.out_byte = {hi_nib, 4'h0};
                end
            end
            default: begin
                d.has_byte = 1'b1;
                d.out_byte = {hi_nib, digit_value(c)};
                phase      = bed_pkg::PH_PLAIN;
            end
        endcase
        if (last) begin
            phase  = bed_pkg::PH_PLAIN;
            hi_nib = '0;
        end
        d.end_of_string = last;
        decoded_q = {decoded_q, d};
    endfunction

    function void check_result(bed_pkg::byte_t data, logic has, logic eos);
        decoded_t d;
        results_seen++;
        if (decoded_q.size() == 0) begin
            $display("%0t: unexpected result has_byte %0b out_byte %02h end_of_string %0b",
                     $time, has, data, eos);
            errors++;
            return;
        end
        d = decoded_q.pop_front();
        if (has !== d.has_byte) begin
            $display("%0t: has_byte mismatch expected %0b actual %0b",
                     $time, d.has_byte, has);
            errors++;
        end
        if (data !== d.out_byte) begin
            $display("%0t: out_byte mismatch expected %02h actual %02h",
                     $time, d.out_byte, data);
            errors++;
        end
        if (eos !== d.end_of_string) begin
            $display("%0t: end_of_string mismatch expected %0b actual %0b",
                     $time, d.end_of_string, eos);
            errors++;
        end
    endfunction

    function int pending();
        return decoded_q.size();
    endfunction
endclass

module backslash_escape_decoder_top_tb;

    localparam int RandomChars = 1900;
    localparam int HoldCycles  = 400;
    localparam int IdleLimit   = 3000;

    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    bed_pkg::byte_t s_tdata  = '0;
    logic           s_tlast  = 1'b0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    bed_pkg::byte_t m_tdata;
    logic           m_tuser;
    logic           m_tlast;

    escape_scoreboard sb = new();

    bit calm;
    bit no_gap;
    bit hold_req;
    int chars_sent;
    int strings_sent;
    int stall_left;
    int idle_cycles;

    backslash_escape_decoder_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bed_pkg::byte_t hex_char(int r);
        if (r < 10) return bed_pkg::CH_0 + bed_pkg::byte_t'(r);
        if (r < 16) return bed_pkg::CH_LA + bed_pkg::byte_t'(r - 10);
        return bed_pkg::CH_UA + bed_pkg::byte_t'(r - 16);
    endfunction

    function automatic bit is_escape_letter(bed_pkg::byte_t c);
        return c == bed_pkg::CH_S || c == bed_pkg::CH_N || c == bed_pkg::CH_T ||
               c == bed_pkg::CH_R || c == bed_pkg::CH_F || c == bed_pkg::CH_V ||
               c == bed_pkg::CH_BSLASH || c == bed_pkg::CH_QUOTE || c == bed_pkg::CH_X;
    endfunction

    function automatic bed_pkg::byte_t pick_escape_letter();
        case ($urandom_range(0, 7))
            0:       return bed_pkg::CH_S;
            1:       return bed_pkg::CH_N;
            2:       return bed_pkg::CH_T;
            3:       return bed_pkg::CH_R;
            4:       return bed_pkg::CH_F;
            5:       return bed_pkg::CH_V;
            6:       return bed_pkg::CH_BSLASH;
            default: return bed_pkg::CH_QUOTE;
        endcase
    endfunction

    task automatic send_char(input bed_pkg::byte_t c, input logic last);
        int gap;
        gap = pick_gap(calm || no_gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge clk); while (!s_tready);
        sb.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_string(input bed_pkg::byte_t chars[$]);
        foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
        strings_sent++;
    endtask

    // Hold the input idle until every queued result has been taken
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    task automatic send_random_string();
        bed_pkg::byte_t chars[$];
        bed_pkg::byte_t c;
        int             tokens;
        int             r;
        if ($urandom_range(0, 99) < 85) begin
            tokens = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                 : $urandom_range(1, 8);
            repeat (tokens) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    do begin
                        c = ($urandom_range(0, 1) == 0)
                            ? bed_pkg::byte_t'($urandom_range(32, 126))
                            : bed_pkg::byte_t'($urandom_range(0, 255));
                    end while (c == bed_pkg::CH_BSLASH);
                    chars = {chars, c};
                end
                else if (r < 70) begin
                    chars = {chars, bed_pkg::CH_BSLASH};
                    chars = {chars, pick_escape_letter()};
                end
                else if (r < 88) begin
                    chars = {chars, bed_pkg::CH_BSLASH};
                    chars = {chars, bed_pkg::CH_X};
                    repeat (2) begin
                        if ($urandom_range(0, 9) != 0)
                            chars = {chars, hex_char($urandom_range(0, 21))};
                        else
                            chars = {chars, bed_pkg::byte_t'($urandom_range(0, 255))};
                    end
                end
                else if (r < 95) begin
                    do c = bed_pkg::byte_t'($urandom_range(0, 255)); while (is_escape_letter(c));
                    chars = {chars, bed_pkg::CH_BSLASH};
                    chars = {chars, c};
                end
                else begin
                    chars = {chars, bed_pkg::byte_t'($urandom_range(0, 255))};
                end
            end
            // cut some strings short so they may end inside an escape
            if ($urandom_range(0, 9) == 0) begin
                r = $urandom_range(1, 2);
                while (r > 0 && chars.size() > 1) begin
                    void'(chars.pop_back());
                    r--;
                end
            end
        end
        else begin
            repeat ($urandom_range(1, 12)) begin
                r = $urandom_range(0, 99);
                if (r < 30)      chars = {chars, bed_pkg::CH_BSLASH};
                else if (r < 45) chars = {chars, bed_pkg::CH_X};
                else if (r < 65) chars = {chars, hex_char($urandom_range(0, 21))};
                else             chars = {chars, bed_pkg::byte_t'($urandom_range(0, 255))};
            end
        end
        send_string(chars);
    endtask

    // Result side: check each transfer, then choose the next ready level
    initial
    begin
        int gap;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HoldCycles - 1;
                m_tready   <= 1'b0;
            end
            else begin
                gap = pick_gap(calm);
                if (gap == 0) begin
                    m_tready <= 1'b1;
                end
                else begin
                    stall_left = gap - 1;
                    m_tready   <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
            $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                     $time, IdleLimit, sb.pending());
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        bed_pkg::byte_t chars[$];
        int             rand_strings;
        int             first_random;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // plain extremes and every named escape
        chars = '{8'h00,
                  bed_pkg::CH_BSLASH, bed_pkg::CH_S, bed_pkg::CH_BSLASH, bed_pkg::CH_N,
                  bed_pkg::CH_BSLASH, bed_pkg::CH_T, bed_pkg::CH_BSLASH, bed_pkg::CH_R,
                  bed_pkg::CH_BSLASH, bed_pkg::CH_F, bed_pkg::CH_BSLASH, bed_pkg::CH_V,
                  bed_pkg::CH_BSLASH, bed_pkg::CH_BSLASH,
                  bed_pkg::CH_BSLASH, bed_pkg::CH_QUOTE,
                  8'hFF};
        send_string(chars);
        // hex in both cases, non-hex digit, unknown letter, trailing backslash
        chars = '{bed_pkg::CH_BSLASH, bed_pkg::CH_X, bed_pkg::CH_LF, bed_pkg::CH_UA,
                  bed_pkg::CH_BSLASH, bed_pkg::CH_X, 8'h7A, bed_pkg::CH_0 + 8'd3,
                  bed_pkg::CH_BSLASH, 8'h71, bed_pkg::CH_BSLASH};
        send_string(chars);
        // string ends right after \x, then after the first digit
        chars = '{bed_pkg::CH_BSLASH, bed_pkg::CH_X};
        send_string(chars);
        chars = '{bed_pkg::CH_BSLASH, bed_pkg::CH_X, bed_pkg::CH_0 + 8'd4};
        send_string(chars);
        wait_drained();

        first_random = chars_sent;
        rand_strings = 0;
        while (chars_sent - first_random < RandomChars) begin
            calm = (rand_strings % 60) < 8;
            if (rand_strings == 40) begin
                hold_req = 1'b1;
                no_gap   = 1'b1;
            end
            if (rand_strings == 50) no_gap = 1'b0;
            if (rand_strings == 100) wait_drained();
            send_random_string();
            rand_strings++;
        end
        calm = 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);

        $display("Sent %0d strings, %0d characters; checked %0d results, %0d errors.",
                 strings_sent, chars_sent, sb.results_seen, sb.errors);
        $display("Covered named, hex, unknown and cut-off escapes under random stalls.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end
        else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
